FILE: rtl/lht_pkg.sv
// Shared types, constants and helpers for the latency histogram / top-N tracker.
// No dependencies; used by every module in rtl/.
package lht_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int NUM_BINS            = 6;
  localparam int BIN_W               = 3;
  localparam int SLOT_W              = 8;
  localparam int DELAY_W             = 32;
  localparam int CPU_W               = 8;
  localparam int THREAD_W            = 22;
  localparam int STAMP_W             = 64;
  localparam int COUNT_W             = 32;
  localparam int TOTAL_W             = 48;

  // histogram bin edges, ms
  localparam logic [DELAY_W-1:0] EDGE_10   = 32'd10;
  localparam logic [DELAY_W-1:0] EDGE_50   = 32'd50;
  localparam logic [DELAY_W-1:0] EDGE_100  = 32'd100;
  localparam logic [DELAY_W-1:0] EDGE_500  = 32'd500;
  localparam logic [DELAY_W-1:0] EDGE_1000 = 32'd1000;

  localparam logic [BIN_W-1:0] BIN_UNDER_10   = 3'd0;
  localparam logic [BIN_W-1:0] BIN_UNDER_50   = 3'd1;
  localparam logic [BIN_W-1:0] BIN_UNDER_100  = 3'd2;
  localparam logic [BIN_W-1:0] BIN_UNDER_500  = 3'd3;
  localparam logic [BIN_W-1:0] BIN_UNDER_1000 = 3'd4;
  localparam logic [BIN_W-1:0] BIN_OVER_1000  = 3'd5;

  typedef struct packed {
    logic [DELAY_W-1:0]  delay_ms;
    logic [CPU_W-1:0]    cpu_id;
    logic [THREAD_W-1:0] thread_id;
    logic [STAMP_W-1:0]  stamp_ns;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] event_count;
    logic [TOTAL_W-1:0] delay_total;
    logic [BIN_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [SLOT_W-1:0]  ring_slot;
    logic               top_replaced;
    logic [SLOT_W-1:0]  top_slot;
    logic [DELAY_W-1:0] top_min;
  } res_t;

  // counters / histogram / ring side
  typedef struct packed {
    logic [COUNT_W-1:0] event_count;
    logic [TOTAL_W-1:0] delay_total;
    logic [BIN_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [SLOT_W-1:0]  ring_slot;
  } stats_t;

  // top-N table side
  typedef struct packed {
    logic               hit;
    logic               replaced;
    logic [SLOT_W-1:0]  slot;
    logic [DELAY_W-1:0] min_delay;
    logic               scan_done;
  } top_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [DELAY_W-1:0] d);
    logic [BIN_W-1:0] b;
    if (d < EDGE_10) begin
      b = BIN_UNDER_10;
    end else if (d < EDGE_50) begin
      b = BIN_UNDER_50;
    end else if (d < EDGE_100) begin
      b = BIN_UNDER_100;
    end else if (d < EDGE_500) begin
      b = BIN_UNDER_500;
    end else if (d < EDGE_1000) begin
      b = BIN_UNDER_1000;
    end else begin
      b = BIN_OVER_1000;
    end
    return b;
  endfunction

endpackage

FILE: rtl/latency_histogram_topn_tracker_unit.sv
// Top level of the latency histogram / top-N tracker: request FSM and result register.
// Depends on lht_pkg, lht_stats and lht_top_table.
//
// Usage:
//   A request (one latency event on req) is taken at a rising edge with start
//   high and busy low. The block then counts it, adds its delay to the total,
//   bumps the histogram bin, writes the ring, and, if the delay beats the
//   tracked table minimum, overwrites that table entry and rescans the table.
//   One result per request appears on res for exactly one cycle with done high;
//   there is no back-pressure, the receiver must take it in that cycle.
//   The result is registered in the finish state: the request first passes
//   the update state and, when it enters the table, the rescan state
//   (one delay-memory read per cycle during the rescan, then the registered
//   read data and the compare stage).
//   busy drops in the done cycle, so the next request may follow at once;
//   a request is never taken before the result of the last one is out.
//   Synchronous reset clears all counters, bins and the table valid bits;
//   entries not yet written read as zero. Any request in flight is dropped.
module latency_histogram_topn_tracker_unit #(
  parameter int TABLE_DEPTH = lht_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lht_pkg::req_t req,
  output logic          done,
  output lht_pkg::res_t res
);

  lht_pkg::state_t    state;
  lht_pkg::state_t    state_next;
  lht_pkg::req_t      req_q;
  lht_pkg::stats_t    stats;
  lht_pkg::top_stat_t top_stat;
  logic               upd;

  lht_stats #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_stats (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .req  (req_q),
    .stats(stats)
  );

  lht_top_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .req (req_q),
    .stat(top_stat)
  );

  // next state; the update cycle decides whether a rescan is needed
  always_comb begin
    state_next = state;
    case (state)
      lht_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lht_pkg::ST_UPDATE;
        end
      end
      lht_pkg::ST_UPDATE: begin
        state_next = top_stat.hit ? lht_pkg::ST_SCAN : lht_pkg::ST_FINISH;
      end
      lht_pkg::ST_SCAN: begin
        if (top_stat.scan_done) begin
          state_next = lht_pkg::ST_FINISH;
        end
      end
      lht_pkg::ST_FINISH: begin
        state_next = lht_pkg::ST_IDLE;
      end
      default: begin
        state_next = lht_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != lht_pkg::ST_IDLE);
  assign upd  = (state == lht_pkg::ST_UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lht_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == lht_pkg::ST_FINISH);
    end
  end

  // request and result payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    if (state == lht_pkg::ST_FINISH) begin
      res.event_count  <= stats.event_count;
      res.delay_total  <= stats.delay_total;
      res.bin_index    <= stats.bin_index;
      res.bin_count    <= stats.bin_count;
      res.ring_slot    <= stats.ring_slot;
      res.top_replaced <= top_stat.replaced;
      res.top_slot     <= top_stat.slot;
      res.top_min      <= top_stat.min_delay;
    end
  end

`ifndef SYNTH
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_done_on_release: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy released without a result");
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> state == lht_pkg::ST_IDLE || state == lht_pkg::ST_UPDATE)
    else $error("result strobe while request still in progress");
`endif

endmodule

FILE: rtl/lht_stats.sv
// Event counter, delay total, six-bin histogram and the recent-event ring memory.
// Depends on lht_pkg.
module lht_stats #(
  parameter int TABLE_DEPTH = lht_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            upd,
  input  lht_pkg::req_t   req,
  output lht_pkg::stats_t stats
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
  localparam int RING_W = lht_pkg::CPU_W + lht_pkg::DELAY_W;

  logic [lht_pkg::COUNT_W-1:0] count_reg;
  logic [lht_pkg::TOTAL_W-1:0] total_reg;
  logic [lht_pkg::COUNT_W-1:0] bin_counts [lht_pkg::NUM_BINS];
  logic [AW-1:0]               ptr;
  logic [lht_pkg::BIN_W-1:0]   bin_q;
  logic [lht_pkg::COUNT_W-1:0] bin_cnt_q;
  logic [RING_W-1:0]           ring_mem [TABLE_DEPTH];

  logic [lht_pkg::BIN_W-1:0]   bin;
  logic [lht_pkg::COUNT_W-1:0] count_next;
  logic [lht_pkg::TOTAL_W-1:0] total_next;
  logic [lht_pkg::COUNT_W-1:0] bin_cnt_next;
  logic [AW-1:0]               ptr_next;

  always_comb begin
    bin          = lht_pkg::bin_of(req.delay_ms);
    count_next   = count_reg + 1'b1;
    total_next   = total_reg + lht_pkg::TOTAL_W'(req.delay_ms);
    bin_cnt_next = bin_counts[bin] + 1'b1;
    // slot tracks count mod depth; a wrap of the count restarts it at zero
    if (count_next == '0) begin
      ptr_next = '0;
    end else if (ptr == LAST) begin
      ptr_next = '0;
    end else begin
      ptr_next = ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
      total_reg <= '0;
      ptr       <= '0;
      for (int i = 0; i < lht_pkg::NUM_BINS; i++) begin
        bin_counts[i] <= '0;
      end
    end else if (upd) begin
      count_reg       <= count_next;
      total_reg       <= total_next;
      ptr             <= ptr_next;
      bin_counts[bin] <= bin_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      bin_q              <= bin;
      bin_cnt_q          <= bin_cnt_next;
      ring_mem[ptr_next] <= {req.cpu_id, req.delay_ms};
    end
  end

  assign stats.event_count = count_reg;
  assign stats.delay_total = total_reg;
  assign stats.bin_index   = bin_q;
  assign stats.bin_count   = bin_cnt_q;
  assign stats.ring_slot   = lht_pkg::SLOT_W'(ptr);

`ifndef SYNTH
  a_ptr_range: assert property (@(posedge clk) disable iff (rst) ptr <= LAST)
    else $error("ring pointer beyond table depth");
`endif

endmodule

FILE: rtl/lht_top_table.sv
// Top-N delay table: delay memory with per-entry valid bits, record memory, and
// the sequential minimum rescan over the delay memory. Depends on lht_pkg.
module lht_top_table #(
  parameter int TABLE_DEPTH = lht_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               upd,
  input  lht_pkg::req_t      req,
  output lht_pkg::top_stat_t stat
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
  localparam int REC_W = lht_pkg::STAMP_W + lht_pkg::THREAD_W + lht_pkg::CPU_W;

  logic [lht_pkg::DELAY_W-1:0] delay_mem [TABLE_DEPTH];
  logic [REC_W-1:0]            rec_mem   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      vbit;

  logic [lht_pkg::DELAY_W-1:0] min_delay;
  logic [AW-1:0]               min_slot;
  logic                        replaced_q;
  logic [AW-1:0]               slot_q;
  logic                        scanning;
  logic                        rd_vld_q;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               idx_q;
  logic [lht_pkg::DELAY_W-1:0] rd_data;
  logic                        rd_vbit;
  logic [lht_pkg::DELAY_W-1:0] best;
  logic [AW-1:0]               best_slot;
  logic [lht_pkg::DELAY_W-1:0] wr_delay_q;

  logic                        hit;
  logic [lht_pkg::DELAY_W-1:0] ent;
  logic [lht_pkg::DELAY_W-1:0] cand;
  logic [AW-1:0]               cand_slot;
  logic                        scan_done;

  always_comb begin
    hit = req.delay_ms > min_delay;
    ent = rd_vbit ? rd_data : '0;
    // strict less-than keeps the lowest slot on ties
    if (idx_q == '0) begin
      cand      = ent;
      cand_slot = '0;
    end else if (ent < best) begin
      cand      = ent;
      cand_slot = idx_q;
    end else begin
      cand      = best;
      cand_slot = best_slot;
    end
    scan_done = rd_vld_q && (idx_q == LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay  <= '0;
      min_slot   <= '0;
      replaced_q <= 1'b0;
      slot_q     <= '0;
      scanning   <= 1'b0;
      rd_vld_q   <= 1'b0;
      vbit       <= '0;
    end else begin
      rd_vld_q <= scanning;
      if (upd) begin
        replaced_q <= hit;
        slot_q     <= hit ? min_slot : '0;
        if (hit) begin
          vbit[min_slot] <= 1'b1;
          scanning       <= 1'b1;
        end
      end else if (scanning && (rd_addr == LAST)) begin
        scanning <= 1'b0;
      end
      if (scan_done) begin
        min_delay <= cand;
        min_slot  <= cand_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= rd_addr;
    if (upd) begin
      rd_addr    <= '0;
      wr_delay_q <= req.delay_ms;
    end else if (scanning) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (rd_vld_q) begin
      best      <= cand;
      best_slot <= cand_slot;
    end
  end

  // memories: write of the new entry, then one read a cycle during the rescan
  always_ff @(posedge clk) begin
    if (upd && hit) begin
      delay_mem[min_slot] <= req.delay_ms;
      rec_mem[min_slot]   <= {req.stamp_ns, req.thread_id, req.cpu_id};
    end
    if (scanning) begin
      rd_data <= delay_mem[rd_addr];
      rd_vbit <= vbit[rd_addr];
    end
  end

  assign stat.hit       = hit;
  assign stat.replaced  = replaced_q;
  assign stat.slot      = lht_pkg::SLOT_W'(slot_q);
  assign stat.min_delay = min_delay;
  assign stat.scan_done = scan_done;

`ifndef SYNTH
  a_no_upd_in_scan: assert property (@(posedge clk) disable iff (rst)
    upd |-> !scanning && !rd_vld_q)
    else $error("update request during rescan");
  a_scan_after_hit: assert property (@(posedge clk) disable iff (rst)
    $rose(scanning) |-> $past(upd) && $past(hit))
    else $error("rescan started without a table write");
  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    scan_done |=> min_delay <= wr_delay_q)
    else $error("rescanned minimum above the entry just written");
`endif

endmodule

FILE: tb/sv/latency_histogram_topn_tracker_unit_tb.sv
// Self-checking testbench for latency_histogram_topn_tracker_unit: directed and random
// latency events, results checked against an in-bench model of counters, bins and top table.
// Depends on lht_pkg and the RTL top level.
`timescale 1ns / 1ps

module latency_histogram_topn_tracker_unit_tb;

  localparam int DEPTH        = lht_pkg::DEFAULT_TABLE_DEPTH;
  localparam int N_RANDOM     = 1700;
  localparam int N_QUIET      = 300;  // tail of the run with no gaps
  localparam int STALL_LIMIT  = 2000; // cycles with no request or result taken
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int MAX_PRINTS   = 100;

  // Model of the block: event counter, delay total, bins, ring and top table,
  // plus the queue of results still to come back.
  class latency_stats_tracker;
    logic [lht_pkg::COUNT_W-1:0]  event_cnt;
    logic [lht_pkg::TOTAL_W-1:0]  delay_sum;
    logic [lht_pkg::COUNT_W-1:0]  bin_cnt[lht_pkg::NUM_BINS];
    logic [lht_pkg::CPU_W-1:0]    ring_cpu[DEPTH];
    logic [lht_pkg::DELAY_W-1:0]  ring_delay[DEPTH];
    logic [lht_pkg::DELAY_W-1:0]  top_delay[DEPTH];
    logic [lht_pkg::CPU_W-1:0]    top_cpu[DEPTH];
    logic [lht_pkg::THREAD_W-1:0] top_thread[DEPTH];
    logic [lht_pkg::STAMP_W-1:0]  top_stamp[DEPTH];
    logic [lht_pkg::DELAY_W-1:0]  min_delay;
    int unsigned                  min_slot;
    lht_pkg::res_t                expected_stats[$];
    int                           fail_count;

    function new();
      event_cnt  = '0;
      delay_sum  = '0;
      min_delay  = '0;
      min_slot   = 0;
      fail_count = 0;
      foreach (bin_cnt[b]) bin_cnt[b] = '0;
      for (int i = 0; i < DEPTH; i++) begin
        ring_cpu[i]   = '0;
        ring_delay[i] = '0;
        top_delay[i]  = '0;
        top_cpu[i]    = '0;
        top_thread[i] = '0;
        top_stamp[i]  = '0;
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (fail_count < MAX_PRINTS)
        $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
    endtask

    // One accepted request: update the model and queue the result it must give.
    function void add_event(lht_pkg::req_t ev);
      lht_pkg::res_t              exp;
      logic [lht_pkg::BIN_W-1:0]  bin;
      logic [lht_pkg::SLOT_W-1:0] rslot;
      int unsigned                tslot;
      exp = '0;
      event_cnt = event_cnt + 1'b1;
      delay_sum = delay_sum + {{(lht_pkg::TOTAL_W-lht_pkg::DELAY_W){1'b0}}, ev.delay_ms};

      if (ev.delay_ms < lht_pkg::EDGE_10)        bin = lht_pkg::BIN_UNDER_10;
      else if (ev.delay_ms < lht_pkg::EDGE_50)   bin = lht_pkg::BIN_UNDER_50;
      else if (ev.delay_ms < lht_pkg::EDGE_100)  bin = lht_pkg::BIN_UNDER_100;
      else if (ev.delay_ms < lht_pkg::EDGE_500)  bin = lht_pkg::BIN_UNDER_500;
      else if (ev.delay_ms < lht_pkg::EDGE_1000) bin = lht_pkg::BIN_UNDER_1000;
      else                                       bin = lht_pkg::BIN_OVER_1000;
      bin_cnt[bin] = bin_cnt[bin] + 1'b1;

      // ring slot comes from the wrapped count
      rslot = lht_pkg::SLOT_W'(event_cnt % DEPTH);
      ring_cpu[rslot]   = ev.cpu_id;
      ring_delay[rslot] = ev.delay_ms;

      // strictly greater only: equal to the minimum stays out
      if (ev.delay_ms > min_delay) begin
        tslot = min_slot;
        top_delay[tslot]  = ev.delay_ms;
        top_cpu[tslot]    = ev.cpu_id;
        top_thread[tslot] = ev.thread_id;
        top_stamp[tslot]  = ev.stamp_ns;
        exp.top_replaced  = 1'b1;
        exp.top_slot      = lht_pkg::SLOT_W'(tslot);
        // rescan after the write; lowest slot wins a tie
        min_delay = top_delay[0];
        min_slot  = 0;
        for (int i = 1; i < DEPTH; i++) begin
          if (top_delay[i] < min_delay) begin
            min_delay = top_delay[i];
            min_slot  = i;
          end
        end
      end

      exp.event_count = event_cnt;
      exp.delay_total = delay_sum;
      exp.bin_index   = bin;
      exp.bin_count   = bin_cnt[bin];
      exp.ring_slot   = rslot;
      exp.top_min     = min_delay;
      expected_stats.push_back(exp);
    endfunction

    task check_stats(lht_pkg::res_t got);
      lht_pkg::res_t exp;
      if (expected_stats.size() == 0) begin
        report("result with no request outstanding", 64'(got.event_count), 64'd0);
      end else begin
        exp = expected_stats.pop_front();
        if (got.event_count !== exp.event_count)
          report("event_count", 64'(got.event_count), 64'(exp.event_count));
        if (got.delay_total !== exp.delay_total)
          report("delay_total", 64'(got.delay_total), 64'(exp.delay_total));
        if (got.bin_index !== exp.bin_index)
          report("bin_index", 64'(got.bin_index), 64'(exp.bin_index));
        if (got.bin_count !== exp.bin_count)
          report("bin_count", 64'(got.bin_count), 64'(exp.bin_count));
        if (got.ring_slot !== exp.ring_slot)
          report("ring_slot", 64'(got.ring_slot), 64'(exp.ring_slot));
        if (got.top_replaced !== exp.top_replaced)
          report("top_replaced", 64'(got.top_replaced), 64'(exp.top_replaced));
        if (got.top_slot !== exp.top_slot)
          report("top_slot", 64'(got.top_slot), 64'(exp.top_slot));
        if (got.top_min !== exp.top_min)
          report("top_min", 64'(got.top_min), 64'(exp.top_min));
      end
    endtask
  endclass

  logic          clk   = 1'b0;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  lht_pkg::req_t req   = '0;
  logic          busy;
  logic          done;
  lht_pkg::res_t res;

  latency_stats_tracker stats = new();
  int stall_cycles = 0;

  latency_histogram_topn_tracker_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Results: done is a one-cycle strobe with no back-pressure, so every
  // strobed cycle is checked against the oldest outstanding request.
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      stats.check_stats(res);
  end

  // Watchdog: give up if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one request and hold it until the block takes it; busy is
  // sampled at the edge, so the accepting edge is the one with busy low.
  // The model is updated here, so stimulus choices see the new state.
  task send_event(lht_pkg::req_t ev);
    req   <= ev;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    stats.add_event(ev);
  endtask

  // Optionally drop start for a random gap after a request.
  task sender_gap(bit allow);
    if (allow && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  initial begin
    lht_pkg::req_t ev;
    logic [lht_pkg::DELAY_W-1:0] directed_delays[$];
    logic [lht_pkg::DELAY_W-1:0] d;
    directed_delays = '{32'd0, 32'd9, 32'd10, 32'd49, 32'd50, 32'd99, 32'd100,
                        32'd499, 32'd500, 32'd999, 32'd1000, 32'hFFFF_FFFF,
                        32'd1, 32'd1, 32'd2, 32'd3, 32'd4,
                        // table now full: min 1, tied at two slots
                        32'd1, 32'd0, 32'd2, 32'd2};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero into an all-zero table stays out, every bin edge,
    // the delay extremes, equal-to-minimum and tie-breaking in the rescan.
    foreach (directed_delays[i]) begin
      ev.delay_ms  = directed_delays[i];
      ev.cpu_id    = i[0] ? '1 : '0;
      ev.thread_id = i[1] ? '1 : '0;
      ev.stamp_ns  = i[0] ? '0 : '1;
      send_event(ev);
      sender_gap(1'b1);
    end

    // Random: mostly histogram-range delays and delays around the current
    // table minimum so the table keeps turning over, plus full-width values and values up to 200000.
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: d = $urandom_range(0, 1200);
        4, 5: begin
          d = stats.min_delay;
          if (d < 32'hFFFF_FFF0)
            d = d + $urandom_range(0, 2);
        end
        6, 7: d = $urandom;
        default: d = $urandom_range(0, 200000);
      endcase
      ev.delay_ms  = d;
      ev.cpu_id    = lht_pkg::CPU_W'($urandom);
      ev.thread_id = lht_pkg::THREAD_W'($urandom);
      ev.stamp_ns  = {$urandom, $urandom};
      send_event(ev);
      sender_gap(n < N_RANDOM - N_QUIET);
    end
    start <= 1'b0;

    while (stats.expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (stats.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lht_pkg.sv
rtl/lht_stats.sv
rtl/lht_top_table.sv
rtl/latency_histogram_topn_tracker_unit.sv
tb/sv/latency_histogram_topn_tracker_unit_tb.sv
